// ===== hw/rtl/base64_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared checks used by the decoder's top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define B64D_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("b64d check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("b64d check failed");

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants shared by the Base64 stream decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int BYTE_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int STORE_W  = 18;
    localparam int GROUP_W  = 24;
    localparam int MAX_RES  = 3;

    // One queue entry: every result caused by one input word
    typedef struct packed {
        logic [MAX_RES-1:0][BYTE_W-1:0] bytes;    // bytes[0] goes out first
        logic [1:0]                     last_idx; // index of the final result
        logic                           byte_ok;  // 0 only for a bare closing result
        logic                           msg_end;  // closes the message
    } b64d_entry_t;

endpackage

// ===== hw/rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Maps each character to its sextet, tracks the group and builds queue entries.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            code_char,
    input  logic                  message_last,
    output logic                  push,
    output b64d_pkg::b64d_entry_t entry
);

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_SL   = 8'h2F;

    logic [b64d_pkg::STORE_W-1:0]  store_reg, store_next;
    logic [1:0]                    count_reg, count_next;
    logic                          stopped_reg, stopped_next;

    logic                          sx_ok;
    logic [b64d_pkg::SEXTET_W-1:0] sx;
    logic [b64d_pkg::STORE_W-1:0]  shifted;
    logic [b64d_pkg::GROUP_W-1:0]  group;
    logic [b64d_pkg::STORE_W-1:0]  fl_store;
    logic [1:0]                    fl_cnt;

    // Character to sextet lookup
    always_comb begin
        sx_ok = 1'b1;
        sx    = '0;
        if (code_char >= CH_UP_A && code_char <= CH_UP_Z) begin
            sx = 6'(code_char - CH_UP_A);
        end else if (code_char >= CH_LO_A && code_char <= CH_LO_Z) begin
            sx = 6'(code_char - 8'd71);
        end else if (code_char >= CH_D0 && code_char <= CH_D9) begin
            sx = 6'(code_char + 8'd4);
        end else if (code_char == CH_PLUS) begin
            sx = 6'd62;
        end else if (code_char == CH_SL) begin
            sx = 6'd63;
        end else begin
            sx_ok = 1'b0;
        end
    end

    assign shifted = {store_reg[11:0], sx};
    assign group   = {store_reg, sx};

    // Group being flushed: the stored one on a stop, else the one with this sextet
    assign fl_store = sx_ok ? shifted : store_reg;
    assign fl_cnt   = sx_ok ? 2'(count_reg + 2'd1) : count_reg;

    // Next state and queue entry
    always_comb begin
        store_next   = store_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        push         = 1'b0;
        entry        = '0;
        if (accept) begin
            if (stopped_reg) begin
                // rest of a stopped message: only the end word closes it
                push = message_last;
            end else if (sx_ok && count_reg == 2'd3) begin
                // fourth sextet releases a full group
                push           = 1'b1;
                entry.bytes[0] = group[23:16];
                entry.bytes[1] = group[15:8];
                entry.bytes[2] = group[7:0];
                entry.last_idx = 2'd2;
                entry.byte_ok  = 1'b1;
                store_next     = '0;
                count_next     = '0;
            end else if (sx_ok && !message_last) begin
                store_next = shifted;
                count_next = 2'(count_reg + 2'd1);
            end else begin
                // flush a partial group: padding, bad character or message end
                store_next   = '0;
                count_next   = '0;
                stopped_next = !sx_ok;
                case (fl_cnt)
                    2'd3: begin
                        push           = 1'b1;
                        entry.bytes[0] = fl_store[17:10];
                        entry.bytes[1] = fl_store[9:2];
                        entry.last_idx = 2'd1;
                        entry.byte_ok  = 1'b1;
                    end
                    2'd2: begin
                        push           = 1'b1;
                        entry.bytes[0] = fl_store[11:4];
                        entry.byte_ok  = 1'b1;
                    end
                    default: begin
                        push = message_last;
                    end
                endcase
            end
            if (message_last) begin
                entry.msg_end = 1'b1;
                store_next    = '0;
                count_next    = '0;
                stopped_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg   <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end else begin
            store_reg   <= store_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ===== hw/rtl/b64d_fifo.sv =====
// ----------------------------------------------------------------------------
// b64d_fifo
// Short entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b64d_pkg::b64d_entry_t wr_entry,
    input  logic                  pop,
    output b64d_pkg::b64d_entry_t head,
    output logic                  empty,
    output logic                  full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::b64d_entry_t mem_reg [DEPTH];
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping; pointers wrap at the last entry
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks queue entries into single result words behind an output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b64d_pkg::b64d_entry_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            data_byte,
    output logic                  byte_valid,
    output logic                  message_end,
    output logic                  last_of_run
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       ok_reg, ok_next;
    logic       end_reg, end_next;
    logic       run_reg, run_next;
    logic       load;
    logic       at_last;

    assign load    = !empty && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.last_idx);
    assign pop     = load && at_last;

    // Next result word
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        ok_next    = ok_reg;
        end_next   = end_reg;
        run_next   = run_reg;
        if (load) begin
            valid_next = 1'b1;
            byte_next  = head.bytes[idx_reg];
            ok_next    = head.byte_ok;
            run_next   = at_last;
            end_next   = at_last && head.msg_end;
            idx_next   = at_last ? 2'd0 : 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        ok_reg   <= ok_next;
        end_reg  <= end_next;
        run_reg  <= run_next;
    end

    assign out_valid   = valid_reg;
    assign data_byte   = byte_reg;
    assign byte_valid  = ok_reg;
    assign message_end = end_reg;
    assign last_of_run = run_reg;

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder, standard alphabet, one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one ASCII character per word in s_tdata[7:0]; s_tlast
//   marks the last character of a message. Master side gives one result per
//   word: decoded byte, byte-valid flag in m_tuser, message end on m_tlast.
//   Four alphabet characters yield three bytes; '=' or any other character
//   flushes the partial group and the rest of that message is skipped. Every
//   message ends with an m_tlast word, a bare one (m_tuser[0] = 0) if needed.
// Timing:
//   A character is taken every cycle while the entry queue has room. Its
//   first result goes through the entry queue and the output register. The
//   back end sends one result per cycle while m_tready is high, so three
//   bytes from one character hold the output for three words; the queue
//   depth (FIFO_DEPTH entries) sets how long input keeps flowing meanwhile.
// Reset and stall:
//   aresetn clears the group, the stop flag, the queue and the output valid
//   flag. While m_tready is low the output word holds, the queue fills, and
//   s_tready drops once it is full.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_char
    input  logic        s_tlast,   // message_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [8] last_of_run, rest zero
    output logic [0:0]  m_tuser,   // [0] byte_valid
    output logic        m_tlast    // message_end
);

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  empty;
    logic                  full;
    b64d_pkg::b64d_entry_t wr_entry;
    b64d_pkg::b64d_entry_t head;
    logic [7:0]            data_byte;
    logic                  byte_valid;
    logic                  message_end;
    logic                  last_of_run;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Decode and group tracking
    b64d_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .code_char    (s_tdata[7:0]),
        .message_last (s_tlast),
        .push         (push),
        .entry        (wr_entry)
    );

    // Entry queue
    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    // Result serializer
    b64d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .message_end (message_end),
        .last_of_run (last_of_run)
    );

    assign m_tdata = {7'b0, last_of_run, data_byte};
    assign m_tuser = byte_valid;
    assign m_tlast = message_end;

    // Checks
    `B64D_ASSERT_IMPL(a_end_is_run_last, m_tvalid && m_tlast, m_tdata[8])
    `B64D_ASSERT_IMPL(a_bare_close, m_tvalid && !m_tuser[0], m_tlast && m_tdata[7:0] == 8'h00)
    `B64D_ASSERT_IMPL(a_no_push_full, push, !full)
    `B64D_ASSERT_NEXT(a_pop_frees, full && pop, !full)

endmodule

// ===== tb/tb_base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Self-checking bench for the streaming Base64 decoder. A shadow decoder
// predicts every output word from the characters taken on the slave side.
// The monitor compares each master-side word, field by field, against the
// oldest prediction. Stimulus is a directed set followed by random messages:
// mostly well-formed groups, with broken and noise messages mixed in. Both
// sides idle at random, and the bench also runs an idle-free burst and a long
// output stall.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_PCT     = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int STALL_CYCLES = 80;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    // One master-side word as the monitor sees it
    typedef struct packed {
        logic [b64d_pkg::BYTE_W-1:0] data_byte;
        logic                        byte_valid;
        logic                        message_end;
        logic                        last_of_run;
    } decoded_word_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic [0:0]        m_tuser;
    logic              m_tlast;

    // Shadow decoder state
    logic [b64d_pkg::STORE_W-1:0] shadow_store   = '0;
    logic [1:0]                   shadow_count   = '0;
    logic                         shadow_stopped = 1'b0;

    decoded_word_t expected_words[$];
    decoded_word_t run_words[$];
    logic [7:0]    msg_chars[$];

    int tx_idle_pct    = IDLE_PCT;
    int rx_idle_pct    = IDLE_PCT;
    int hold_request   = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int words_checked  = 0;
    int chars_sent     = 0;
    int messages_sent  = 0;
    int bare_closings  = 0;
    int live_chars     = 0;

    base64_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Six-bit value of an alphabet character, -1 outside the alphabet
    function automatic int sextet_value(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return int'(ch) - int'("A");
        if (ch >= "a" && ch <= "z") return int'(ch) - int'("a") + 26;
        if (ch >= "0" && ch <= "9") return int'(ch) - int'("0") + 52;
        if (ch == "+") return 62;
        if (ch == "/") return 63;
        return -1;
    endfunction

    // Alphabet character for a six-bit value
    function automatic logic [7:0] alphabet_char(input int v);
        if (v < 26) return 8'(int'("A") + v);
        if (v < 52) return 8'(int'("a") + v - 26);
        if (v < 62) return 8'(int'("0") + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    function automatic decoded_word_t byte_word(input logic [7:0] b, input logic ok);
        decoded_word_t w;
        w.data_byte   = b;
        w.byte_valid  = ok;
        w.message_end = 1'b0;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    // Append a word to the words of the current character
    function automatic void append_run(input decoded_word_t w);
        run_words.insert(run_words.size(), w);
    endfunction

    // Release the bytes of an unfinished group (one byte fewer than values)
    function automatic void flush_group();
        if (shadow_count == 2'd2) begin
            append_run(byte_word(shadow_store[11:4], 1'b1));
        end else if (shadow_count == 2'd3) begin
            append_run(byte_word(shadow_store[17:10], 1'b1));
            append_run(byte_word(shadow_store[9:2], 1'b1));
        end
        shadow_store = '0;
        shadow_count = '0;
    endfunction

    // Advance the shadow decoder by one character, queue the words it causes
    function automatic void predict_char(input logic [7:0] ch, input logic last);
        int             v;
        logic [23:0]    group;
        decoded_word_t  w;
        v = sextet_value(ch);
        if (!shadow_stopped) begin
            if (v < 0) begin
                flush_group();
                shadow_stopped = 1'b1;
            end else if (shadow_count == 2'd3) begin
                group = {shadow_store, 6'(v)};
                append_run(byte_word(group[23:16], 1'b1));
                append_run(byte_word(group[15:8], 1'b1));
                append_run(byte_word(group[7:0], 1'b1));
                shadow_store = '0;
                shadow_count = '0;
            end else begin
                shadow_store = {shadow_store[11:0], 6'(v)};
                shadow_count = shadow_count + 2'd1;
            end
        end
        if (last) begin
            flush_group();
            if (run_words.size() == 0) begin
                append_run(byte_word(8'h00, 1'b0));
                bare_closings++;
            end
            w = run_words.pop_back();
            w.message_end = 1'b1;
            append_run(w);
            shadow_stopped = 1'b0;
        end
        if (run_words.size() != 0) begin
            w = run_words.pop_back();
            w.last_of_run = 1'b1;
            append_run(w);
        end
        while (run_words.size() != 0)
            expected_words.insert(expected_words.size(), run_words.pop_front());
    endfunction

    // Send one character word; valid stays up after acceptance
    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (!(shadow_stopped && !last)) live_chars++;
        predict_char(ch, last);
        chars_sent++;
        if (last) messages_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_char(text[i], i == text.len() - 1);
    endtask

    task automatic send_built_message();
        for (int i = 0; i < msg_chars.size(); i++)
            send_char(msg_chars[i], i == msg_chars.size() - 1);
    endtask

    // Random message: mostly well-formed with padding, some broken, some noise
    task automatic build_message();
        int kind;
        int groups;
        int tail;
        int len;
        kind = $urandom_range(99);
        msg_chars.delete();
        if (kind < 75) begin
            groups = $urandom_range(3);
            tail   = $urandom_range(2);
            if (groups == 0 && tail == 0) groups = 1;
            repeat (4 * groups)
                msg_chars.insert(msg_chars.size(), alphabet_char($urandom_range(63)));
            if (tail == 1) begin
                repeat (2) msg_chars.insert(msg_chars.size(), alphabet_char($urandom_range(63)));
                repeat (2) msg_chars.insert(msg_chars.size(), "=");
            end else if (tail == 2) begin
                repeat (3) msg_chars.insert(msg_chars.size(), alphabet_char($urandom_range(63)));
                msg_chars.insert(msg_chars.size(), "=");
            end
        end else if (kind < 90) begin
            len = $urandom_range(10, 1);
            repeat (len) msg_chars.insert(msg_chars.size(), alphabet_char($urandom_range(63)));
            msg_chars[$urandom_range(len - 1)] = 8'($urandom_range(255));
        end else begin
            len = $urandom_range(6, 1);
            repeat (len) msg_chars.insert(msg_chars.size(), 8'($urandom_range(255)));
        end
    endtask

    // Whole groups ending on the last character
    task automatic test_full_groups();
        send_text("TWFu");
    endtask

    // Padding after two and three values; trailing '=' hits a stopped message
    task automatic test_padding();
        send_text("QQ==");
        send_text("QUI=");
    endtask

    // Message of a single value: no byte, bare closing word
    task automatic test_short_groups();
        send_text("Q");
    endtask

    // Characters outside the alphabet, at a group boundary and mid-group,
    // followed by ignored characters and a stopped close
    task automatic test_invalid_chars();
        send_text("/+9a");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char("z", 1'b0);
        send_char("A", 1'b0);
        send_char(8'h80, 1'b0);
        send_char("B", 1'b0);
        send_char("C", 1'b1);
    endtask

    task automatic test_random_messages(input int target);
        while (live_chars < target) begin
            build_message();
            send_built_message();
        end
    endtask

    // Neither side idles
    task automatic test_no_idle_burst(input int count);
        int stop_at;
        stop_at     = live_chars + count;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_messages(stop_at);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // Receiver holds off while input keeps coming, so the queue fills up
    task automatic test_output_stall();
        int stop_at;
        stop_at      = live_chars + 30;
        tx_idle_pct  = 0;
        hold_request = STALL_CYCLES;
        test_random_messages(stop_at);
        tx_idle_pct  = IDLE_PCT;
    endtask

    // Receiver ready: random idling, or a counted hold-off on request
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each output word with the oldest prediction
    always @(posedge aclk) begin : check_words
        decoded_word_t got;
        decoded_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.data_byte   = m_tdata[7:0];
            got.byte_valid  = m_tuser[0];
            got.message_end = m_tlast;
            got.last_of_run = m_tdata[8];
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected word: byte %h valid %b end %b run_last %b",
                             $realtime, got.data_byte, got.byte_valid,
                             got.message_end, got.last_of_run);
            end else begin
                want = expected_words.pop_front();
                if (got !== want || m_tdata[15:9] !== 7'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: mismatch: exp byte %h valid %b end %b run_last %b,",
                                  " got byte %h valid %b end %b run_last %b pad %h"},
                                 $realtime, want.data_byte, want.byte_valid,
                                 want.message_end, want.last_of_run, got.data_byte,
                                 got.byte_valid, got.message_end, got.last_of_run,
                                 m_tdata[15:9]);
                end
            end
        end
    end

    // Test sequence
    initial begin : run_tests
        int drain_cycles;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_full_groups();
        test_padding();
        test_short_groups();
        test_invalid_chars();
        test_random_messages(140);
        test_no_idle_burst(50);
        test_output_stall();
        test_random_messages(245);
        s_tvalid <= 1'b0;

        // Drain outstanding words, then let the pipeline settle
        drain_cycles = 0;
        while (expected_words.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_words.size() != 0) begin
            $display("%0d predicted words never arrived", expected_words.size());
            mismatch_count += expected_words.size();
        end

        $display("Decoded %0d characters in %0d messages; %0d output words compared.",
                 chars_sent, messages_sent, words_checked);
        $display("Covered padding, stray bytes, short groups, %0d bare closings, %s",
                 bare_closings, "an output stall and an idle-free burst.");
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
